### hdl/dlsq_pkg.sv
// Shared types and constants for the delta-list sleep queue.
// No dependencies; compile first.
`default_nettype none

package dlsq_pkg;

    localparam int IdW        = 8;
    localparam int DurW       = 32;
    localparam int KindW      = 2;
    localparam int MaxResults = 16;
    localparam int WokenW     = 5;

    localparam logic CmdSleep = 1'b0;
    localparam logic CmdTick  = 1'b1;

    localparam logic [KindW-1:0] KindAccepted = 2'd0;
    localparam logic [KindW-1:0] KindRejected = 2'd1;
    localparam logic [KindW-1:0] KindWoken    = 2'd2;
    localparam logic [KindW-1:0] KindNone     = 2'd3;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_SHIFT,
        RD_HEAD
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_REDUCE,
        WR_SHIFT,
        WR_INSERT,
        WR_TICK
    } t_wr_sel;

    typedef struct packed {
        logic             load;
        logic             walk_step;
        logic             idx_load;
        logic             idx_dec;
        logic             push;
        logic             pop;
        logic             emit;
        logic             emit_last;
        logic [KindW-1:0] emit_kind;
        t_rd_sel          rd;
        t_wr_sel          wr;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_at_end;
        logic idx_at_pos;
        logic delta_ge;
        logic delta_zero;
        logic dec_zero;
        logic woken_max;
        logic out_free;
    } t_dp_status;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_WALK_RD   = 10'b00_0000_0010,
        S_WALK_CMP  = 10'b00_0000_0100,
        S_SHIFT_RD  = 10'b00_0000_1000,
        S_SHIFT_WR  = 10'b00_0001_0000,
        S_TICK_RD   = 10'b00_0010_0000,
        S_TICK_CHK  = 10'b00_0100_0000,
        S_WAKE_NEXT = 10'b00_1000_0000,
        S_WAKE_CHK  = 10'b01_0000_0000,
        S_EMIT      = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

### hdl/dlsq_in_if.sv
// Command channel interface: valid/ready handshake with sleep/tick payload.
// Depends on dlsq_pkg.
`default_nettype none

interface dlsq_in_if;
    import dlsq_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [IdW-1:0]  thread_id;
    logic [DurW-1:0] duration;

    modport source (output valid, command, thread_id, duration, input ready);
    modport sink   (input valid, command, thread_id, duration, output ready);
endinterface

`default_nettype wire

### hdl/dlsq_out_if.sv
// Result channel interface: valid/ready handshake with wake/status payload.
// Depends on dlsq_pkg.
`default_nettype none

interface dlsq_out_if;
    import dlsq_pkg::*;

    logic             valid;
    logic             ready;
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   woken_thread;
    logic             last;

    modport source (output valid, kind, woken_thread, last, input ready);
    modport sink   (input valid, kind, woken_thread, last, output ready);
endinterface

`default_nettype wire

### hdl/dlsq_dp.sv
// Datapath: circular queue memories, walk/shift registers and result register.
// Depends on dlsq_pkg; driven by dlsq_ctrl through t_dp_cmd.
`default_nettype none

module dlsq_dp #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlsq_pkg::t_dp_cmd             i_cmd,
    output dlsq_pkg::t_dp_status          o_status,
    input  logic [dlsq_pkg::IdW-1:0]      i_thread_id,
    input  logic [dlsq_pkg::DurW-1:0]     i_duration,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dlsq_pkg::KindW-1:0]    o_kind,
    output logic [dlsq_pkg::IdW-1:0]      o_woken_thread,
    output logic                          o_last
);
    import dlsq_pkg::*;

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int TidW = (THREAD_ID_BITS < IdW) ? THREAD_ID_BITS : IdW;

    logic [DurW-1:0] r_mem_delta [QUEUE_DEPTH];
    logic [TidW-1:0] r_mem_tid   [QUEUE_DEPTH];

    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_idx;
    logic [WokenW-1:0] r_woken;
    logic [DurW-1:0]   r_rem;
    logic [TidW-1:0]   r_tid;
    logic [TidW-1:0]   r_cur_tid;
    logic [DurW-1:0]   r_rd_delta;
    logic [TidW-1:0]   r_rd_tid;
    logic              r_out_valid;
    logic [KindW-1:0]  r_out_kind;
    logic              r_out_last;
    logic [TidW-1:0]   r_out_tid;

    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    logic [DurW-1:0] wr_delta;
    logic [TidW-1:0] wr_tid;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(offs);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_head;
        unique case (i_cmd.rd)
            RD_POS:   rd_addr = f_phys(r_head, r_pos);
            RD_SHIFT: rd_addr = f_phys(r_head, r_idx - CW'(1));
            RD_HEAD:  rd_addr = r_head;
            RD_NONE:  rd_en   = 1'b0;
            default:  rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en    = 1'b1;
        wr_addr  = r_head;
        wr_delta = r_rd_delta;
        wr_tid   = r_rd_tid;
        unique case (i_cmd.wr)
            WR_REDUCE: begin
                wr_addr  = f_phys(r_head, r_pos);
                wr_delta = r_rd_delta - r_rem;
            end
            WR_SHIFT: begin
                wr_addr = f_phys(r_head, r_idx);
            end
            WR_INSERT: begin
                wr_addr  = f_phys(r_head, r_pos);
                wr_delta = r_rem;
                wr_tid   = r_tid;
            end
            WR_TICK: begin
                wr_delta = r_rd_delta - DurW'(1);
            end
            WR_NONE: wr_en = 1'b0;
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_delta[wr_addr] <= wr_delta;
            r_mem_tid[wr_addr]   <= wr_tid;
        end
        if (rd_en) begin
            r_rd_delta <= r_mem_delta[rd_addr];
            r_rd_tid   <= r_mem_tid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_woken <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos   <= '0;
                r_woken <= '0;
            end else if (i_cmd.walk_step) begin
                r_pos <= r_pos + CW'(1);
            end
            if (i_cmd.idx_load) begin
                r_idx <= r_count;
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= f_phys(r_head, CW'(1));
                r_woken <= r_woken + WokenW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tid <= i_thread_id[TidW-1:0];
            r_rem <= i_duration;
        end else if (i_cmd.walk_step) begin
            r_rem <= r_rem - r_rd_delta;
        end
        if (i_cmd.pop) begin
            r_cur_tid <= r_rd_tid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.emit_kind;
            r_out_last <= i_cmd.emit_last;
            r_out_tid  <= r_cur_tid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_last         = r_out_last;
    assign o_woken_thread = (r_out_kind == KindWoken) ? IdW'(r_out_tid) : '0;

    assign o_status.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_status.empty      = (r_count == '0);
    assign o_status.pos_at_end = (r_pos == r_count);
    assign o_status.idx_at_pos = (r_idx == r_pos);
    assign o_status.delta_ge   = (r_rd_delta >= r_rem);
    assign o_status.delta_zero = (r_rd_delta == '0);
    assign o_status.dec_zero   = (r_rd_delta <= DurW'(1));
    assign o_status.woken_max  = (r_woken == WokenW'(MaxResults));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_status.full)
        else $error("insert into full queue");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_status.empty)
        else $error("wake from empty queue");
    a_pop_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_status.woken_max)
        else $error("too many wakeups on one tick");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.out_free)
        else $error("result overwritten before transaction");
`endif

endmodule

`default_nettype wire

### hdl/dlsq_ctrl.sv
// Controller state machine: sequences walk, shift, insert, tick and wake steps.
// Depends on dlsq_pkg; commands dlsq_dp through t_dp_cmd.
`default_nettype none

module dlsq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_command,
    input  dlsq_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output dlsq_pkg::t_dp_cmd    o_cmd
);
    import dlsq_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [KindW-1:0] r_kind;
    logic [KindW-1:0] n_kind;

    always_comb begin
        n_state          = r_state;
        n_kind           = r_kind;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.rd         = RD_NONE;
        o_cmd.wr         = WR_NONE;
        o_cmd.emit_kind  = KindNone;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_command == CmdSleep) begin
                        if (i_status.full) begin
                            n_kind  = KindRejected;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end else if (i_status.empty) begin
                        n_kind  = KindNone;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_TICK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                if (i_status.pos_at_end) begin
                    o_cmd.idx_load = 1'b1;
                    n_state        = S_SHIFT_RD;
                end else begin
                    o_cmd.rd = RD_POS;
                    n_state  = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_status.delta_ge) begin
                    o_cmd.wr       = WR_REDUCE;
                    o_cmd.idx_load = 1'b1;
                    n_state        = S_SHIFT_RD;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_WALK_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_status.idx_at_pos) begin
                    o_cmd.wr   = WR_INSERT;
                    o_cmd.push = 1'b1;
                    n_kind     = KindAccepted;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.rd = RD_SHIFT;
                    n_state  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr      = WR_SHIFT;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_SHIFT_RD;
            end
            S_TICK_RD: begin
                o_cmd.rd = RD_HEAD;
                n_state  = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                if (i_status.dec_zero) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_WAKE_NEXT;
                end else begin
                    o_cmd.wr = WR_TICK;
                    n_kind   = KindNone;
                    n_state  = S_EMIT;
                end
            end
            S_WAKE_NEXT: begin
                if (i_status.empty || i_status.woken_max) begin
                    n_kind  = KindWoken;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd = RD_HEAD;
                    n_state  = S_WAKE_CHK;
                end
            end
            S_WAKE_CHK: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KindWoken;
                    if (i_status.delta_zero) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_WAKE_NEXT;
                    end else begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_kind;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KindNone;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

### hdl/delta_list_sleep_queue.sv
// Top level of the delta-list sleep queue: controller plus datapath.
// Depends on dlsq_pkg, dlsq_in_if, dlsq_out_if, dlsq_ctrl and dlsq_dp.
//
//   port   dir  transaction
//   i_in   in   command (sleep/tick), thread_id, duration
//   o_out  out  kind, woken_thread, last (one or more per command)
//
// Sleep: walks the held entries to the insert point, shifts the later entries up one
// slot, then inserts; a sleep into a full queue is rejected without a walk.
// Tick: an empty queue reports none; otherwise the head delta is decremented or, at
// one or below, the head and each following zero-delta entry wake, up to MaxResults.
// Reset clears state, pointers, counters and the result valid; memories need no clearing pass.
// A stalled result holds the next emit; a new command is taken only in the idle state.
`default_nettype none

module delta_list_sleep_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlsq_in_if.sink     i_in,
    dlsq_out_if.source  o_out
);
    import dlsq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    dlsq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_status     (status),
        .o_in_ready   (in_ready),
        .o_cmd        (cmd)
    );

    dlsq_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_thread_id    (i_in.thread_id),
        .i_duration     (i_in.duration),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_woken_thread (o_out.woken_thread),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
